// File: hdl/lce_pkg.sv
package lce_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [15:0]        t_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] curve_x;
    logic signed [15:0] curve_y;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

endpackage

// File: hdl/lce_front.sv
module lce_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lce_pkg::in_item_t         in_data,
  input  logic                      cfg_we,
  input  logic [lce_pkg::CNT_W-1:0] cfg_wdata,
  output logic [lce_pkg::CNT_W-1:0] n_points,
  output lce_pkg::queue_head_t      head,
  input  logic                      pop
);

  lce_pkg::in_item_t q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [lce_pkg::CNT_W-1:0] cfg_r, cfg_nxt;
  logic       push;
  logic       do_pop;

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
    cfg_nxt = cfg_we ? cfg_wdata : cfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      cfg_r <= lce_pkg::CNT_W'(1);
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_data;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      n_points = lce_pkg::CNT_W'(1);
    end else if (cfg_r > lce_pkg::CNT_W'(lce_pkg::MAX_POINTS)) begin
      n_points = lce_pkg::CNT_W'(lce_pkg::MAX_POINTS);
    end else begin
      n_points = cfg_r;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

endmodule

// File: hdl/lce_back.sv
module lce_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lce_pkg::CNT_W-1:0] n_points,
  input  lce_pkg::queue_head_t      head,
  output logic                      pop,
  output logic                      out_valid,
  output lce_pkg::out_item_t        out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_NEXT = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SHR  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         st_r, st_nxt;
  logic [4:0]         n_r, i_r, j_r;
  logic [15:0]        t_r;
  logic signed [41:0] b_r;
  logic signed [59:0] prod_r;
  logic [47:0]        dvd_r;
  logic [3:0]         rem_r, md_r;
  logic               neg_r;
  logic [2:0]         cnt_r;
  logic signed [63:0] acc_x_r, acc_y_r;
  logic               out_valid_r;
  lce_pkg::out_item_t out_data_r;

  logic signed [15:0] mem_x [16];
  logic signed [15:0] mem_y [16];
  logic signed [15:0] rd_x_r, rd_y_r;

  logic               wr_en;
  logic [15:0]        t_clamp;
  logic [15:0]        t_max;
  logic [4:0]         nm1;
  logic signed [16:0] diff;
  logic [59:0]        pmag;
  logic [59:0]        prnd;
  logic [3:0]         md_c;
  logic [47:0]        dvd_c;
  logic [3:0]         rem_c;
  logic [4:0]         r5;
  logic [47:0]        q_sat;
  logic signed [41:0] b_fin;
  logic signed [57:0] px, py;

  function automatic logic signed [15:0] sat_round(input logic signed [63:0] a);
    logic [63:0] m;
    logic [39:0] r;
    logic signed [15:0] res;
    m = a[63] ? (64'd0 - a) : a;
    m = m + 64'h80_0000;
    r = m[63:24];
    if (!a[63]) begin
      res = (r > 40'd32767) ? 16'sh7FFF : r[15:0];
    end else begin
      res = (r > 40'd32768) ? 16'sh8000 : 16'(40'd0 - r);
    end
    return res;
  endfunction

  assign pop   = (st_r == S_IDLE) && head.valid;
  assign wr_en = pop && (head.item.cmd == lce_pkg::CMD_WRITE);

  always_comb begin
    nm1     = n_points - 5'd1;
    t_max   = {nm1[3:0], 12'd0};
    t_clamp = (head.item.t_value > t_max) ? t_max : head.item.t_value;
    diff    = $signed({1'b0, t_r}) - $signed({1'b0, j_r[3:0], 12'd0});
    pmag    = prod_r[59] ? (60'd0 - prod_r) : prod_r;
    prnd    = pmag + 60'd2048;
    md_c    = (i_r > j_r) ? 4'(i_r - j_r) : 4'(j_r - i_r);
    q_sat   = (dvd_r > 48'h100_0000_0000) ? 48'h100_0000_0000 : dvd_r;
    b_fin   = neg_r ? -$signed(42'(q_sat)) : $signed(42'(q_sat));
    px      = rd_x_r * b_r;
    py      = rd_y_r * b_r;
    dvd_c   = dvd_r;
    rem_c   = rem_r;
    for (int k = 0; k < 8; k++) begin
      r5 = {rem_c, dvd_c[47]};
      dvd_c = {dvd_c[46:0], 1'b0};
      if (r5 >= {1'b0, md_r}) begin
        r5 = r5 - {1'b0, md_r};
        dvd_c[0] = 1'b1;
      end
      rem_c = r5[3:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (head.valid && head.item.cmd == lce_pkg::CMD_EVAL) begin
          st_nxt = S_INIT;
        end
      end
      S_INIT: st_nxt = S_NEXT;
      S_NEXT: begin
        if (j_r == n_r) begin
          st_nxt = S_ACC;
        end else if (j_r != i_r) begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: st_nxt = S_SHR;
      S_SHR: st_nxt = S_DIV;
      S_DIV: st_nxt = (cnt_r == 3'd5) ? S_FIN : S_DIV;
      S_FIN: st_nxt = S_NEXT;
      S_ACC: st_nxt = (i_r + 5'd1 == n_r) ? S_OUT : S_INIT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= (st_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[head.item.point_index] <= head.item.point_x;
      mem_y[head.item.point_index] <= head.item.point_y;
    end
    rd_x_r <= mem_x[i_r[3:0]];
    rd_y_r <= mem_y[i_r[3:0]];
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        n_r     <= n_points;
        t_r     <= t_clamp;
        i_r     <= 5'd0;
        acc_x_r <= 64'sd0;
        acc_y_r <= 64'sd0;
      end
      S_INIT: begin
        b_r <= 42'sd16777216;
        j_r <= 5'd0;
      end
      S_NEXT: begin
        if (j_r != n_r && j_r == i_r) begin
          j_r <= j_r + 5'd1;
        end
      end
      S_MUL: prod_r <= 60'(b_r * diff);
      S_SHR: begin
        md_r  <= md_c;
        dvd_r <= prnd[59:12] + {44'd0, 1'b0, md_c[3:1]};
        neg_r <= prod_r[59] ^ (i_r < j_r);
        rem_r <= 4'd0;
        cnt_r <= 3'd0;
      end
      S_DIV: begin
        dvd_r <= dvd_c;
        rem_r <= rem_c;
        cnt_r <= cnt_r + 3'd1;
      end
      S_FIN: begin
        b_r <= b_fin;
        j_r <= j_r + 5'd1;
      end
      S_ACC: begin
        acc_x_r <= acc_x_r + 64'(px);
        acc_y_r <= acc_y_r + 64'(py);
        i_r     <= i_r + 5'd1;
      end
      S_OUT: begin
        out_data_r.curve_x <= sat_round(acc_x_r);
        out_data_r.curve_y <= sat_round(acc_y_r);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/lagrange_curve_evaluator.sv
// An evaluate item is worked through basis factor by basis factor, each factor built by
// the shared multiply, round and eight-bit-a-cycle divide; the datapath finishes one
// evaluate item before it pops the next, and a write item is stored as it is popped.
// A two-item queue lets start be taken while one works.
// The result strobe is high for one cycle and the receiver cannot stall it. Synchronous
// active-low reset empties the queue, idles the datapath and sets the point count to one.
module lagrange_curve_evaluator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lce_pkg::in_item_t         in_data,
  output logic                      out_valid,
  output lce_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [lce_pkg::CNT_W-1:0] cfg_wdata
);

  logic [lce_pkg::CNT_W-1:0] n_points;
  lce_pkg::queue_head_t      head;
  logic                      pop;

  lce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .n_points  (n_points),
    .head      (head),
    .pop       (pop)
  );

  lce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_points  (n_points),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: hdl/lce_checker.sv
module lce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input lce_pkg::out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or result strobe after reset");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item taken");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result item has unknown bits");

endmodule

bind lagrange_curve_evaluator lce_checker u_lce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
